[src/ppp_pkg.sv]
// Shared types, command codes, register indexes and width helpers of the point projector.
`default_nettype none

package ppp_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int LANES         = 3;
    localparam int QUOT_BITS     = 32;
    localparam int SIZE_BITS     = 15;

    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_PROJECT = 2'd1;
    localparam logic [1:0] CMD_SHADOW  = 2'd2;
    localparam logic [1:0] CMD_NONE    = 2'd3;

    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = 15'd640;
    localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = 15'd480;

    // Clip coordinate width: three shifted 64-bit products plus a 32-bit term.
    function automatic int clip_w(input int f);
        return 66 - f;
    endfunction

    // Scaled numerator width: magnitude of a clip sum times a screen size times 2^f.
    function automatic int num_w(input int f);
        return clip_w(f) + 1 + SIZE_BITS + f;
    endfunction

    // Divider remainder width.
    function automatic int rem_w(input int f);
        return (num_w(f) > clip_w(f) + QUOT_BITS) ? num_w(f) : clip_w(f) + QUOT_BITS;
    endfunction

    typedef struct packed {
        logic [1:0] cmd;
        logic       ovf;
    } item_ctl_t;

    typedef struct packed {
        logic             shadow;
        logic             ok;
        logic [LANES-1:0] neg;
    } side_t;

endpackage

`default_nettype wire

[src/ppp_shear.sv]
// Input register and shadow shear stages of the point projector.
`default_nettype none

module ppp_shear #(
    parameter int F = ppp_pkg::FRACTION_BITS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              command,
    input  logic [3:0]              coef_index,
    input  logic signed [31:0]      coef_value,
    input  logic signed [31:0]      point_x,
    input  logic signed [31:0]      point_y,
    input  logic signed [31:0]      point_z,
    input  logic signed [31:0]      light_dx,
    input  logic signed [31:0]      light_dy,
    output logic                    out_valid,
    input  logic                    out_ready,
    output ppp_pkg::item_ctl_t      out_ctl,
    output logic [3:0]              out_index,
    output logic signed [31:0]      out_value,
    output logic signed [31:0]      out_x,
    output logic signed [31:0]      out_y,
    output logic signed [31:0]      out_z
);

    localparam int SW = 65 - F;

    logic                a_v_reg;
    logic [1:0]          a_cmd_reg;
    logic [3:0]          a_idx_reg;
    logic signed [31:0]  a_val_reg, a_x_reg, a_y_reg, a_z_reg, a_dx_reg, a_dy_reg;

    logic                b_v_reg;
    logic [1:0]          b_cmd_reg;
    logic [3:0]          b_idx_reg;
    logic signed [31:0]  b_val_reg, b_x_reg, b_y_reg, b_z_reg;
    logic signed [63:0]  b_pdx_reg, b_pdy_reg;

    logic                c_v_reg;
    ppp_pkg::item_ctl_t  c_ctl_reg;
    logic [3:0]          c_idx_reg;
    logic signed [31:0]  c_val_reg, c_x_reg, c_y_reg, c_z_reg;

    logic                rdy_a, rdy_b, rdy_c;
    logic signed [63:0]  pdx_next, pdy_next;
    logic signed [SW-1:0] shx_next, shy_next;
    logic                fit_x, fit_y;
    ppp_pkg::item_ctl_t  ctl_next;
    logic signed [31:0]  x_next, y_next, z_next;

    assign rdy_c    = !c_v_reg || out_ready;
    assign rdy_b    = !b_v_reg || rdy_c;
    assign rdy_a    = !a_v_reg || rdy_b;
    assign in_ready = rdy_a;

    always_comb
    begin
        pdx_next = a_z_reg * a_dx_reg;
        pdy_next = a_z_reg * a_dy_reg;
    end

    always_comb
    begin
        shx_next = SW'(b_x_reg) + SW'(b_pdx_reg >>> F);
        shy_next = SW'(b_y_reg) + SW'(b_pdy_reg >>> F);
        fit_x    = (&shx_next[SW-1:31]) || !(|shx_next[SW-1:31]);
        fit_y    = (&shy_next[SW-1:31]) || !(|shy_next[SW-1:31]);
        ctl_next.cmd = b_cmd_reg;
        if (b_cmd_reg == ppp_pkg::CMD_SHADOW)
        begin
            ctl_next.ovf = !(fit_x && fit_y);
            x_next       = shx_next[31:0];
            y_next       = shy_next[31:0];
            z_next       = '0;
        end
        else
        begin
            ctl_next.ovf = 1'b0;
            x_next       = b_x_reg;
            y_next       = b_y_reg;
            z_next       = b_z_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a)
                a_v_reg <= in_valid && (command != ppp_pkg::CMD_NONE);
            if (rdy_b)
                b_v_reg <= a_v_reg;
            if (rdy_c)
                c_v_reg <= b_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_a && in_valid)
        begin
            a_cmd_reg <= command;
            a_idx_reg <= coef_index;
            a_val_reg <= coef_value;
            a_x_reg   <= point_x;
            a_y_reg   <= point_y;
            a_z_reg   <= point_z;
            a_dx_reg  <= light_dx;
            a_dy_reg  <= light_dy;
        end
        if (rdy_b && a_v_reg)
        begin
            b_cmd_reg <= a_cmd_reg;
            b_idx_reg <= a_idx_reg;
            b_val_reg <= a_val_reg;
            b_x_reg   <= a_x_reg;
            b_y_reg   <= a_y_reg;
            b_z_reg   <= a_z_reg;
            b_pdx_reg <= pdx_next;
            b_pdy_reg <= pdy_next;
        end
        if (rdy_c && b_v_reg)
        begin
            c_ctl_reg <= ctl_next;
            c_idx_reg <= b_idx_reg;
            c_val_reg <= b_val_reg;
            c_x_reg   <= x_next;
            c_y_reg   <= y_next;
            c_z_reg   <= z_next;
        end
    end

    assign out_valid = c_v_reg;
    assign out_ctl   = c_ctl_reg;
    assign out_index = c_idx_reg;
    assign out_value = c_val_reg;
    assign out_x     = c_x_reg;
    assign out_y     = c_y_reg;
    assign out_z     = c_z_reg;

endmodule

`default_nettype wire

[src/ppp_clip.sv]
// Coefficient matrix, matrix products and clip row sums of the point projector.
`default_nettype none

module ppp_clip #(
    parameter int F = ppp_pkg::FRACTION_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  ppp_pkg::item_ctl_t                   in_ctl,
    input  logic [3:0]                           in_index,
    input  logic signed [31:0]                   in_value,
    input  logic signed [31:0]                   in_x,
    input  logic signed [31:0]                   in_y,
    input  logic signed [31:0]                   in_z,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output ppp_pkg::item_ctl_t                   out_ctl,
    output logic signed [ppp_pkg::clip_w(F)-1:0] out_clip [4]
);

    localparam int CW = ppp_pkg::clip_w(F);

    logic [31:0]         coef_reg [16];

    logic                d_v_reg;
    ppp_pkg::item_ctl_t  d_ctl_reg;
    logic signed [63:0]  d_prod_reg [12];
    logic signed [31:0]  d_tr_reg [4];

    logic                e_v_reg;
    ppp_pkg::item_ctl_t  e_ctl_reg;
    logic signed [CW-1:0] e_row_reg [4];

    logic                rdy_d, rdy_e;
    logic signed [31:0]  coord [3];
    logic signed [63:0]  prod_next [12];
    logic signed [CW-1:0] row_next [4];

    assign rdy_e    = !e_v_reg || out_ready;
    assign rdy_d    = !d_v_reg || rdy_e;
    assign in_ready = rdy_d;

    assign coord[0] = in_x;
    assign coord[1] = in_y;
    assign coord[2] = in_z;

    // Entry 4*c+r of the column-major matrix scales coordinate c into clip row r.
    always_comb
    begin
        for (int i = 0; i < 12; i++)
            prod_next[i] = $signed(coef_reg[i]) * coord[i / 4];
    end

    always_comb
    begin
        for (int r = 0; r < 4; r++)
            row_next[r] = CW'(d_prod_reg[r] >>> F) + CW'(d_prod_reg[r + 4] >>> F)
                        + CW'(d_prod_reg[r + 8] >>> F) + CW'(d_tr_reg[r]);
    end

    // A load writes the matrix here, so items ahead of it still see the old entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
                coef_reg[i] <= '0;
        end
        else if (rdy_d && in_valid && (in_ctl.cmd == ppp_pkg::CMD_LOAD))
        begin
            coef_reg[in_index] <= in_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
        end
        else
        begin
            if (rdy_d)
                d_v_reg <= in_valid && (in_ctl.cmd != ppp_pkg::CMD_LOAD);
            if (rdy_e)
                e_v_reg <= d_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_d && in_valid)
        begin
            d_ctl_reg <= in_ctl;
            for (int i = 0; i < 12; i++)
                d_prod_reg[i] <= prod_next[i];
            for (int r = 0; r < 4; r++)
                d_tr_reg[r] <= coef_reg[r + 12];
        end
        if (rdy_e && d_v_reg)
        begin
            e_ctl_reg <= d_ctl_reg;
            for (int r = 0; r < 4; r++)
                e_row_reg[r] <= row_next[r];
        end
    end

    assign out_valid = e_v_reg;
    assign out_ctl   = e_ctl_reg;
    assign out_clip  = e_row_reg;

endmodule

`default_nettype wire

[src/ppp_div.sv]
// Pipelined restoring divider, one quotient bit per stage, three lanes sharing one divisor.
`default_nettype none

module ppp_div #(
    parameter int F = ppp_pkg::FRACTION_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  ppp_pkg::side_t                      in_side,
    input  logic [ppp_pkg::rem_w(F)-1:0]        in_rem [ppp_pkg::LANES],
    input  logic [ppp_pkg::clip_w(F)-1:0]       in_d,
    output logic                                out_valid,
    input  logic                                out_ready,
    output ppp_pkg::side_t                      out_side,
    output logic [ppp_pkg::QUOT_BITS-1:0]       out_q [ppp_pkg::LANES]
);

    localparam int XW = ppp_pkg::rem_w(F);
    localparam int DW = ppp_pkg::clip_w(F);
    localparam int NS = ppp_pkg::QUOT_BITS;
    localparam int NL = ppp_pkg::LANES;

    logic            cur_v    [NS+1];
    ppp_pkg::side_t  cur_side [NS+1];
    logic [XW-1:0]   cur_rem  [NS+1][NL];
    logic [NS-1:0]   cur_q    [NS+1][NL];
    logic [DW-1:0]   cur_d    [NS+1];
    logic            rdy      [NS+1];

    assign cur_v[0]    = in_valid;
    assign cur_side[0] = in_side;
    assign cur_d[0]    = in_d;
    assign rdy[NS]     = out_ready;
    assign in_ready    = rdy[0];

    for (genvar l = 0; l < NL; l++)
    begin : g_lane_in
        assign cur_rem[0][l] = in_rem[l];
        assign cur_q[0][l]   = '0;
        assign out_q[l]      = cur_q[NS][l];
    end

    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        localparam int B = NS - 1 - s;

        logic            v_reg;
        ppp_pkg::side_t  side_reg;
        logic [XW-1:0]   rem_reg  [NL];
        logic [NS-1:0]   q_reg    [NL];
        logic [DW-1:0]   d_reg;
        logic [XW-1:0]   rem_next [NL];
        logic [NS-1:0]   q_next   [NL];
        logic [XW-1:0]   dsh;

        assign rdy[s] = !v_reg || rdy[s+1];

        always_comb
        begin
            dsh = XW'(cur_d[s]) << B;
            for (int l = 0; l < NL; l++)
            begin
                q_next[l] = cur_q[s][l];
                if (cur_rem[s][l] >= dsh)
                begin
                    rem_next[l]  = cur_rem[s][l] - dsh;
                    q_next[l][B] = 1'b1;
                end
                else
                begin
                    rem_next[l] = cur_rem[s][l];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg <= 1'b0;
            else if (rdy[s])
                v_reg <= cur_v[s];
        end

        always_ff @(posedge clk)
        begin
            if (rdy[s] && cur_v[s])
            begin
                side_reg <= cur_side[s];
                d_reg    <= cur_d[s];
                for (int l = 0; l < NL; l++)
                begin
                    rem_reg[l] <= rem_next[l];
                    q_reg[l]   <= q_next[l];
                end
            end
        end

        assign cur_v[s+1]    = v_reg;
        assign cur_side[s+1] = side_reg;
        assign cur_d[s+1]    = d_reg;

        for (genvar l = 0; l < NL; l++)
        begin : g_lane
            assign cur_rem[s+1][l] = rem_reg[l];
            assign cur_q[s+1][l]   = q_reg[l];
        end
    end

    assign out_valid = cur_v[NS];
    assign out_side  = cur_side[NS];

endmodule

`default_nettype wire

[src/perspective_point_projector.sv]
// Perspective point projector: a pipeline from world point to screen position and depth.
//
// Input channel (in_valid / in_stall): one beat carries a command and all of its fields.
// A load beat writes one matrix coefficient and gives no result; a project or shadow beat
// gives exactly one result beat; command 3 is taken and dropped.
// Output channel (out_valid / out_stall): valid_res, screen_x, pixel_y and depth.
// Throughput: one beat per cycle while out_stall is low. Depth: 41 register stages, namely
// 3 input and shear stages, 2 matrix stages, 3 ratio setup stages, 32 divider stages
// (one quotient bit each) and the output register.
// Screen size registers are written through cfg_we / cfg_index / cfg_data and are meant to
// change only while no beat is in flight.
// Reset clears the matrix to zero, sets the screen to 640 by 480 and empties the pipeline.
// When the receiver stalls, the output register holds its beat; upstream stages keep
// filling empty slots, and in_stall rises once the pipeline is full.
`default_nettype none

module perspective_point_projector #(
    parameter int FRACTION_BITS = ppp_pkg::FRACTION_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [ppp_pkg::SIZE_BITS-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    command,
    input  logic [3:0]                    coef_index,
    input  logic signed [31:0]            coef_value,
    input  logic signed [31:0]            point_x,
    input  logic signed [31:0]            point_y,
    input  logic signed [31:0]            point_z,
    input  logic signed [31:0]            light_dx,
    input  logic signed [31:0]            light_dy,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          valid_res,
    output logic signed [31:0]            screen_x,
    output logic signed [31:0]            pixel_y,
    output logic signed [31:0]            depth
);

    localparam int F  = FRACTION_BITS;
    localparam int CW = ppp_pkg::clip_w(F);
    localparam int MW = CW + 1;
    localparam int DW = CW;
    localparam int NW = ppp_pkg::num_w(F);
    localparam int XW = ppp_pkg::rem_w(F);
    localparam int NL = ppp_pkg::LANES;
    localparam int QB = ppp_pkg::QUOT_BITS;
    localparam int SB = ppp_pkg::SIZE_BITS;
    localparam logic signed [CW-1:0] MinDepthQ = CW'(((1 << F) + 5000) / 10000);

    logic [SB-1:0] width_reg, height_reg;

    // Shear to matrix stages.
    logic                sh_valid, sh_ready, sh_in_ready;
    ppp_pkg::item_ctl_t  sh_ctl;
    logic [3:0]          sh_index;
    logic signed [31:0]  sh_value, sh_x, sh_y, sh_z;

    // Matrix stages to ratio setup.
    logic                cl_valid, cl_in_ready;
    ppp_pkg::item_ctl_t  cl_ctl;
    logic signed [CW-1:0] cl_clip [4];

    logic                f_v_reg;
    ppp_pkg::side_t      f_side_reg;
    logic [MW-1:0]       f_mag_reg [NL];
    logic [DW-1:0]       f_d_reg;

    logic                g_v_reg;
    ppp_pkg::side_t      g_side_reg;
    logic [NW-1:0]       g_num_reg [NL];
    logic [DW-1:0]       g_d_reg;

    logic                h_v_reg;
    ppp_pkg::side_t      h_side_reg;
    logic [XW-1:0]       h_rem_reg [NL];
    logic [DW-1:0]       h_d_reg;

    logic                dv_valid, dv_in_ready;
    ppp_pkg::side_t      dv_side;
    logic [QB-1:0]       dv_q [NL];

    logic                o_v_reg, o_ok_reg;
    logic signed [31:0]  o_x_reg, o_y_reg, o_z_reg;

    logic                rdy_f, rdy_g, rdy_h, rdy_o;

    logic signed [MW-1:0] n_next [NL];
    ppp_pkg::side_t      f_side_next;
    logic [MW-1:0]       f_mag_next [NL];
    logic [SB-1:0]       mult [NL];
    logic [NW-1:0]       g_num_next [NL];
    logic [XW-1:0]       limit [NL];
    logic [NL-1:0]       ovf;
    ppp_pkg::side_t      h_side_next;
    logic signed [31:0]  res [NL];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= ppp_pkg::WIDTH_RESET;
            height_reg <= ppp_pkg::HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ppp_pkg::REG_SCREEN_WIDTH:  width_reg  <= cfg_data;
                ppp_pkg::REG_SCREEN_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    ppp_shear #(.F(F)) u_shear (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (sh_in_ready),
        .command    (command),
        .coef_index (coef_index),
        .coef_value (coef_value),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_z    (point_z),
        .light_dx   (light_dx),
        .light_dy   (light_dy),
        .out_valid  (sh_valid),
        .out_ready  (sh_ready),
        .out_ctl    (sh_ctl),
        .out_index  (sh_index),
        .out_value  (sh_value),
        .out_x      (sh_x),
        .out_y      (sh_y),
        .out_z      (sh_z)
    );

    assign in_stall = !sh_in_ready;
    assign sh_ready = cl_in_ready;

    ppp_clip #(.F(F)) u_clip (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sh_valid),
        .in_ready  (cl_in_ready),
        .in_ctl    (sh_ctl),
        .in_index  (sh_index),
        .in_value  (sh_value),
        .in_x      (sh_x),
        .in_y      (sh_y),
        .in_z      (sh_z),
        .out_valid (cl_valid),
        .out_ready (rdy_f),
        .out_ctl   (cl_ctl),
        .out_clip  (cl_clip)
    );

    assign rdy_o = !o_v_reg || !out_stall;
    assign rdy_h = !h_v_reg || dv_in_ready;
    assign rdy_g = !g_v_reg || rdy_h;
    assign rdy_f = !f_v_reg || rdy_g;

    // Numerators of the three ratios: cx+cw, cw-cy and cz+cw, split into sign and magnitude.
    always_comb
    begin
        n_next[0] = MW'(cl_clip[0]) + MW'(cl_clip[3]);
        n_next[1] = MW'(cl_clip[3]) - MW'(cl_clip[1]);
        n_next[2] = MW'(cl_clip[2]) + MW'(cl_clip[3]);
        for (int l = 0; l < NL; l++)
        begin
            f_side_next.neg[l] = n_next[l][MW-1];
            f_mag_next[l]      = n_next[l][MW-1] ? MW'(-n_next[l]) : MW'(n_next[l]);
        end
        f_side_next.shadow = (cl_ctl.cmd == ppp_pkg::CMD_SHADOW);
        f_side_next.ok     = !cl_ctl.ovf && (cl_clip[3] > MinDepthQ);
    end

    always_comb
    begin
        mult[0] = width_reg;
        mult[1] = height_reg;
        mult[2] = SB'(1);
        for (int l = 0; l < NL; l++)
            g_num_next[l] = (NW'(f_mag_reg[l]) * NW'(mult[l])) << F;
    end

    // A quotient above the signed 32-bit limit overflows: that is the numerator reaching
    // d*2^31 for a positive result, or d*(2^31+1) for a negative one.
    always_comb
    begin
        for (int l = 0; l < NL; l++)
        begin
            limit[l] = (XW'(g_d_reg) << (QB - 1)) + (g_side_reg.neg[l] ? XW'(g_d_reg) : '0);
            ovf[l]   = XW'(g_num_reg[l]) >= limit[l];
        end
        h_side_next    = g_side_reg;
        h_side_next.ok = g_side_reg.ok && !ovf[0] && !ovf[1] && (g_side_reg.shadow || !ovf[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_v_reg <= 1'b0;
            g_v_reg <= 1'b0;
            h_v_reg <= 1'b0;
            o_v_reg <= 1'b0;
        end
        else
        begin
            if (rdy_f)
                f_v_reg <= cl_valid;
            if (rdy_g)
                g_v_reg <= f_v_reg;
            if (rdy_h)
                h_v_reg <= g_v_reg;
            if (rdy_o)
                o_v_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_f && cl_valid)
        begin
            f_side_reg <= f_side_next;
            f_d_reg    <= {cl_clip[3][CW-2:0], 1'b0};
            for (int l = 0; l < NL; l++)
                f_mag_reg[l] <= f_mag_next[l];
        end
        if (rdy_g && f_v_reg)
        begin
            g_side_reg <= f_side_reg;
            g_d_reg    <= f_d_reg;
            for (int l = 0; l < NL; l++)
                g_num_reg[l] <= g_num_next[l];
        end
        if (rdy_h && g_v_reg)
        begin
            h_side_reg <= h_side_next;
            h_d_reg    <= g_d_reg;
            for (int l = 0; l < NL; l++)
                h_rem_reg[l] <= XW'(g_num_reg[l]);
        end
    end

    ppp_div #(.F(F)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (h_v_reg),
        .in_ready  (dv_in_ready),
        .in_side   (h_side_reg),
        .in_rem    (h_rem_reg),
        .in_d      (h_d_reg),
        .out_valid (dv_valid),
        .out_ready (rdy_o),
        .out_side  (dv_side),
        .out_q     (dv_q)
    );

    always_comb
    begin
        for (int l = 0; l < NL; l++)
            res[l] = dv_side.neg[l] ? -$signed(dv_q[l]) : $signed(dv_q[l]);
    end

    always_ff @(posedge clk)
    begin
        if (rdy_o && dv_valid)
        begin
            o_ok_reg <= dv_side.ok;
            o_x_reg  <= dv_side.ok ? res[0] : '0;
            o_y_reg  <= dv_side.ok ? res[1] : '0;
            o_z_reg  <= (dv_side.ok && !dv_side.shadow) ? res[2] : '0;
        end
    end

    assign out_valid = o_v_reg;
    assign valid_res = o_ok_reg;
    assign screen_x  = o_x_reg;
    assign pixel_y   = o_y_reg;
    assign depth     = o_z_reg;

`ifndef ASSERT_OFF
    // A rejected point shows zero in every field.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !valid_res |-> screen_x == 0 && pixel_y == 0 && depth == 0)
        else $error("rejected point carries nonzero fields");

    // With the output register empty, the ready chain reaches the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while output register is empty");

    // A width write lands in the register on the next edge.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && cfg_index == ppp_pkg::REG_SCREEN_WIDTH |=> width_reg == $past(cfg_data))
        else $error("screen width write lost");
`endif

endmodule

`default_nettype wire
